// File: rtl/lbd_pkg.sv
// ---------------------------------------------------------------------------
// lbd_pkg
// Shared codes, voltage windows and types for the ladder button decoder.
// ---------------------------------------------------------------------------
package lbd_pkg;

  // input word kinds, carried on in_tuser
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_MAIN     = 2'd1;
  localparam logic [1:0] CMD_SELECTOR = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS  = 2'd1;

  localparam int unsigned LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] PRESS_TICKS_RST = 16'd5;
  localparam logic [LIMIT_W-1:0] HOLD_TICKS_RST  = 16'd100;

  // button slots, in output flag order
  localparam int unsigned NUM_BUTTONS  = 5;
  localparam int unsigned BTN_DIRECT   = 0;
  localparam int unsigned BTN_SPK_A    = 1;
  localparam int unsigned BTN_SPK_B    = 2;
  localparam int unsigned BTN_LOUD     = 3;
  localparam int unsigned BTN_SELECTOR = 4;

  // ladder voltage windows, exclusive bounds
  localparam logic [7:0] WIN_DIRECT_HI = 8'd10;
  localparam logic [7:0] WIN_SPK_A_LO  = 8'd32;
  localparam logic [7:0] WIN_SPK_A_HI  = 8'd52;
  localparam logic [7:0] WIN_SPK_B_LO  = 8'd91;
  localparam logic [7:0] WIN_SPK_B_HI  = 8'd121;
  localparam logic [7:0] WIN_LOUD_LO   = 8'd141;
  localparam logic [7:0] WIN_LOUD_HI   = 8'd161;
  localparam logic [7:0] WIN_SEL_HI    = 8'd10;

  // per-button control from the decode stage
  typedef struct packed {
    logic step;       // a powered sample for this button's group is applied
    logic in_window;  // reading falls inside this button's window
  } btn_ctrl_t;

endpackage

// File: rtl/lbd_button.sv
// ---------------------------------------------------------------------------
// lbd_button
// Phase tracker for one ladder button: released, triggered, pressed, hold.
// ---------------------------------------------------------------------------
module lbd_button #(
  parameter int unsigned TIMER_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lbd_pkg::btn_ctrl_t            ctrl,
  input  logic [TIMER_WIDTH-1:0]        tick_count,
  input  logic [lbd_pkg::LIMIT_W-1:0]   press_ticks,
  input  logic [lbd_pkg::LIMIT_W-1:0]   hold_ticks,
  output logic                          release_evt
);
  import lbd_pkg::*;

  localparam int unsigned CMP_W = (TIMER_WIDTH > LIMIT_W) ? TIMER_WIDTH : LIMIT_W;

  typedef enum logic [1:0] {
    PH_RELEASED,
    PH_TRIGGERED,
    PH_PRESSED,
    PH_HOLD
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] stamp_r, stamp_nxt;
  logic [TIMER_WIDTH-1:0] diff;
  logic [TIMER_WIDTH-1:0] mag;
  logic                   press_reached;
  logic                   hold_reached;

  // magnitude of the wrapped time since trigger
  assign diff = tick_count - stamp_r;
  assign mag  = diff[TIMER_WIDTH-1] ? (~diff + 1'b1) : diff;
  assign press_reached = CMP_W'(mag) >= CMP_W'(press_ticks);
  assign hold_reached  = CMP_W'(mag) >= CMP_W'(hold_ticks);

  // phase step for one sample
  always_comb begin
    phase_nxt   = phase_r;
    stamp_nxt   = stamp_r;
    release_evt = 1'b0;
    if (ctrl.step) begin
      if (ctrl.in_window) begin
        case (phase_r)
          PH_RELEASED: begin
            phase_nxt = PH_TRIGGERED;
            stamp_nxt = tick_count;
          end
          PH_TRIGGERED: begin
            if (press_reached) phase_nxt = PH_PRESSED;
          end
          PH_PRESSED: begin
            if (hold_reached) phase_nxt = PH_HOLD;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end else begin
        release_evt = (phase_r == PH_PRESSED);
        phase_nxt   = PH_RELEASED;
      end
    end
  end

  // phase and stamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RELEASED;
    end else begin
      phase_r <= phase_nxt;
    end
    stamp_r <= stamp_nxt;
  end

endmodule

// File: rtl/ladder_button_press_hold_decoder.sv
// ---------------------------------------------------------------------------
// ladder_button_press_hold_decoder
// Press/hold decoder for two resistor-ladder button groups.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one word per tick or ADC sample; in_tuser is the kind (tick,
//           main group sample, selector sample), in_tdata the reading and
//           the power flag. Samples with power off change nothing.
//   out_* : one word per input word, five toggle flags, set when a button
//           leaves the pressed phase on that word.
//   cfg_* : writes press_ticks (index 0) and hold_ticks (index 1); always
//           ready, to be used only while no words are in flight.
// out_tvalid rises after input accept once the word has passed an input register,
// then the window compares, elapsed-time magnitude and phase update in one
// pass into the output register. One word is taken every cycle while the
// output is not stalled.
// When the receiver stalls, the output register holds its word and the input
// register takes one more; in_tready then drops until out_tready returns.
// Reset (rst_n low, synchronous) clears both stages, the tick counter and all
// button phases, and restores press_ticks = 5 and hold_ticks = 100.
// ---------------------------------------------------------------------------
module ladder_button_press_hold_decoder #(
  parameter int unsigned TIMER_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [7:0] adc_value, [8] power_on
  input  logic [1:0]                        in_tuser,   // [1:0] command
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [0] toggle_direct,
                                                        // [1] toggle_speakers_a,
                                                        // [2] toggle_speakers_b,
                                                        // [3] toggle_loudness,
                                                        // [4] toggle_mute
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lbd_pkg::LIMIT_W-1:0]       cfg_data
);
  import lbd_pkg::*;

  logic                   s1_valid_r;
  logic [1:0]             s1_cmd_r;
  logic [7:0]             s1_adc_r;
  logic                   s1_power_r;
  logic                   s1_adv;
  logic                   out_valid_r;
  logic [NUM_BUTTONS-1:0] out_flags_r;
  logic [NUM_BUTTONS-1:0] flags;
  logic [NUM_BUTTONS-1:0] in_win;
  logic                   main_step;
  logic                   sel_step;
  logic [TIMER_WIDTH-1:0] tick_count_r;
  logic [LIMIT_W-1:0]     press_ticks_r;
  logic [LIMIT_W-1:0]     hold_ticks_r;
  btn_ctrl_t              btn_ctrl [NUM_BUTTONS];

  // handshake: stage 1 moves on when the output register is free or drains
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_flags_r};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      s1_cmd_r   <= in_tuser;
      s1_adc_r   <= in_tdata[7:0];
      s1_power_r <= in_tdata[8];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r <= PRESS_TICKS_RST;
      hold_ticks_r  <= HOLD_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRESS_TICKS: press_ticks_r <= cfg_data;
        REG_HOLD_TICKS:  hold_ticks_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // tick counter, wraps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
    end else if (s1_adv && s1_cmd_r == CMD_TICK) begin
      tick_count_r <= tick_count_r + 1'b1;
    end
  end

  // window decode
  assign in_win[BTN_DIRECT]   = s1_adc_r < WIN_DIRECT_HI;
  assign in_win[BTN_SPK_A]    = (s1_adc_r > WIN_SPK_A_LO) && (s1_adc_r < WIN_SPK_A_HI);
  assign in_win[BTN_SPK_B]    = (s1_adc_r > WIN_SPK_B_LO) && (s1_adc_r < WIN_SPK_B_HI);
  assign in_win[BTN_LOUD]     = (s1_adc_r > WIN_LOUD_LO) && (s1_adc_r < WIN_LOUD_HI);
  assign in_win[BTN_SELECTOR] = s1_adc_r < WIN_SEL_HI;

  assign main_step = s1_adv && s1_power_r && (s1_cmd_r == CMD_MAIN);
  assign sel_step  = s1_adv && s1_power_r && (s1_cmd_r == CMD_SELECTOR);

  // one phase tracker per button
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    assign btn_ctrl[b].step      = (b == BTN_SELECTOR) ? sel_step : main_step;
    assign btn_ctrl[b].in_window = in_win[b];

    lbd_button #(
      .TIMER_WIDTH (TIMER_WIDTH)
    ) u_button (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (btn_ctrl[b]),
      .tick_count  (tick_count_r),
      .press_ticks (press_ticks_r),
      .hold_ticks  (hold_ticks_r),
      .release_evt (flags[b])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_flags_r <= flags;
    end
  end

  // checks
  a_groups_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_flags_r[BTN_SELECTOR] && (|out_flags_r[BTN_LOUD:BTN_DIRECT])))
    else $error("main and selector flags in one word");

  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r == CMD_TICK) |=>
      (tick_count_r == TIMER_WIDTH'($past(tick_count_r) + 1'b1)))
    else $error("tick counter did not advance by one");

  a_idle_word_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !(s1_power_r && (s1_cmd_r == CMD_MAIN || s1_cmd_r == CMD_SELECTOR)))
      |=> (out_flags_r == '0))
    else $error("flag set on a tick or unpowered word");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input blocked without a stalled output");

endmodule
